[rtl/assert_macros.svh]
// assertion helpers for the rtl, included by rce_serializer
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property with asynchronous active-low reset disable
`define RCE_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// property checked only while a condition holds
`define RCE_ASSERT_IF(label, clk, rstn, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) else $error(msg);

`endif

[rtl/rce_pkg.sv]
// ----------------------------------------------------------------------------
// rce_pkg
// types, constants and fragment builder for the rv32 to x86 code emitter
// ----------------------------------------------------------------------------
package rce_pkg;

  localparam int unsigned FragBytes = 64;
  localparam int unsigned CntW      = 6;

  localparam logic [6:0] OpLui    = 7'h37;
  localparam logic [6:0] OpAuipc  = 7'h17;
  localparam logic [6:0] OpJal    = 7'h6f;
  localparam logic [6:0] OpJalr   = 7'h67;
  localparam logic [6:0] OpBranch = 7'h63;
  localparam logic [6:0] OpAlu    = 7'h33;
  localparam logic [6:0] OpAluImm = 7'h13;
  localparam logic [6:0] OpStore  = 7'h23;
  localparam logic [6:0] OpLoad   = 7'h03;
  localparam logic [6:0] OpSystem = 7'h73;

  localparam logic [6:0]  SubFunct7 = 7'b0100000;
  localparam logic [31:0] PcOfs     = 32'd128;
  localparam logic [7:0]  MovEcxImm = 8'hb9;
  localparam logic [7:0]  RetOp     = 8'hc3;

  localparam logic       CfgSavePrologue = 1'b0;
  localparam logic       CfgInvalidCode  = 1'b1;

  typedef struct packed {
    logic [FragBytes-1:0][7:0] b;
    logic [CntW-1:0]           n;
  } frag_t;

  function automatic frag_t p8(frag_t f, logic [7:0] v);
    f.b[f.n] = v;
    f.n      = f.n + CntW'(1);
    return f;
  endfunction

  function automatic frag_t p32(frag_t f, logic [31:0] v);
    f = p8(f, v[7:0]);
    f = p8(f, v[15:8]);
    f = p8(f, v[23:16]);
    f = p8(f, v[31:24]);
    return f;
  endfunction

  function automatic frag_t p3(frag_t f, logic [7:0] a, logic [7:0] b2, logic [7:0] c);
    f = p8(f, a);
    f = p8(f, b2);
    f = p8(f, c);
    return f;
  endfunction

  // [rbx] form for x0, [rbx+disp8] otherwise
  function automatic frag_t reg_op(frag_t f, logic [7:0] opc, logic [7:0] modrm,
                                   logic [4:0] r);
    f = p8(f, opc);
    if (r == 5'd0) begin
      f = p8(f, modrm);
    end else begin
      f = p8(f, modrm | 8'h40);
      f = p8(f, {1'b0, r, 2'b00});
    end
    return f;
  endfunction

  function automatic frag_t epilog(frag_t f, logic [31:0] code);
    if (code == 32'd0) begin
      f = p3(f, 8'h31, 8'hc0, RetOp);
    end else begin
      f = p8(f, 8'hb8);
      f = p32(f, code);
      f = p8(f, RetOp);
    end
    return f;
  endfunction

  function automatic frag_t store_rd(frag_t f, logic [4:0] rd);
    if (rd != 5'd0) f = p3(f, 8'h89, 8'h43, {1'b0, rd, 2'b00});
    return f;
  endfunction

  function automatic frag_t pc_inc(frag_t f);
    f = p3(f, 8'h83, 8'h83, 8'h80);
    f = p3(f, 8'h00, 8'h00, 8'h00);
    f = p8(f, 8'h04);
    return f;
  endfunction

  function automatic frag_t cyc_inc(frag_t f);
    f = p3(f, 8'h48, 8'hff, 8'h83);
    f = p32(f, 32'h0000_0088);
    return f;
  endfunction

  function automatic frag_t pc_ld(frag_t f, logic [7:0] opc);
    f = p8(f, opc);
    f = p8(f, 8'h83);
    f = p32(f, PcOfs);
    return f;
  endfunction

  function automatic logic [7:0] setcc_code(logic [2:0] f3);
    case (f3)
      3'd0:    return 8'h95;
      3'd1:    return 8'h94;
      3'd4:    return 8'h9d;
      3'd5:    return 8'h9c;
      3'd6:    return 8'h93;
      3'd7:    return 8'h92;
      default: return 8'h00;
    endcase
  endfunction

  function automatic frag_t build(logic [31:0] w, logic save, logic [31:0] inv);
    frag_t       f;
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] iimm, simm, off, bimm, word;
    logic        plain, sub, ok, st;
    f    = '0;
    opc  = w[6:0];
    rd   = w[11:7];
    f3   = w[14:12];
    rs1  = w[19:15];
    rs2  = w[24:20];
    f7   = w[31:25];
    iimm = {{20{w[31]}}, w[31:20]};
    simm = {{20{w[31]}}, w[31:25], w[11:7]};
    bimm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0} - 32'd4;
    plain = (f3 == 3'd0) || (f3 == 3'd4) || (f3 == 3'd6) || (f3 == 3'd7);
    sub   = (f7 == SubFunct7);
    st    = (opc == OpStore);
    ok    = 1'b1;
    word  = '0;
    off   = '0;
    if (save && (opc == OpLui || opc == OpAuipc || opc == OpJal || opc == OpJalr ||
                 opc == OpBranch || opc == OpAlu || opc == OpAluImm))
      f = p3(f, 8'h48, 8'h89, 8'hcb);
    case (opc)
      OpLui, OpAuipc: begin
        if (opc == OpLui) begin
          f = p8(f, 8'hb8);
        end else begin
          f = pc_ld(f, 8'h8b);
          f = p8(f, 8'h05);
        end
        f = p32(f, {w[31:12], 12'd0});
        f = store_rd(f, rd);
        f = pc_inc(f);
        f = cyc_inc(f);
      end
      OpJal, OpJalr: begin
        f = pc_ld(f, 8'h8b);
        f = p3(f, 8'h83, 8'hc0, 8'h04);
        f = store_rd(f, rd);
        if (opc == OpJal) begin
          off = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0} - 32'd4;
        end else begin
          f   = reg_op(f, 8'h8b, 8'h03, rs1);
          off = iimm - 32'd4;
        end
        if (off != 32'd0) begin
          f = p8(f, 8'h05);
          f = p32(f, off);
        end
        f = pc_ld(f, 8'h89);
        f = cyc_inc(f);
        f = epilog(f, 32'd0);
      end
      OpBranch: begin
        f = reg_op(f, 8'h8b, 8'h03, rs1);
        f = reg_op(f, 8'h3b, 8'h03, rs2);
        if (f3 == 3'd2 || f3 == 3'd3) f = epilog(f, inv);
        else f = p3(f, 8'h0f, setcc_code(f3), 8'hc1);
        f = p8(f, 8'hb8);
        f = p32(f, bimm);
        f = p3(f, 8'hc0, 8'he1, 8'h05);
        f = p3(f, 8'h48, 8'hd3, 8'he0);
        f = p3(f, 8'h83, 8'hc0, 8'h04);
        f = p3(f, 8'h01, 8'h83, 8'h80);
        f = p3(f, 8'h00, 8'h00, 8'h00);
        f = cyc_inc(f);
        f = epilog(f, 32'd0);
      end
      OpAlu: begin
        if (rd != 5'd0) begin
          if (rs1 == rd && !sub && plain) begin
            f = reg_op(f, 8'h8b, 8'h03, rs2);
            case (f3)
              3'd0:    f = p8(f, 8'h01);
              3'd4:    f = p8(f, 8'h31);
              3'd6:    f = p8(f, 8'h09);
              default: f = p8(f, 8'h21);
            endcase
            f = p8(f, 8'h43);
            f = p8(f, {1'b0, rs1, 2'b00});
          end else begin
            f = reg_op(f, 8'h8b, 8'h03, rs1);
            case (f3)
              3'd0: f = reg_op(f, sub ? 8'h2b : 8'h03, 8'h03, rs2);
              3'd1: begin
                f = reg_op(f, 8'h8b, 8'h0b, rs2);
                f = p8(f, 8'hd3);
                f = p8(f, 8'he0);
              end
              3'd2, 3'd3: begin
                f = reg_op(f, 8'h3b, 8'h03, rs2);
                f = p3(f, 8'h31, 8'hc0, RetOp);
                f = p3(f, 8'h0f, (f3 == 3'd2) ? 8'h9c : 8'h92, 8'hc0);
              end
              3'd5: begin
                f = reg_op(f, 8'h8b, 8'h0b, rs2);
                f = p8(f, 8'hd3);
                f = p8(f, sub ? 8'hf8 : 8'he8);
              end
              3'd4:    f = reg_op(f, 8'h33, 8'h03, rs2);
              3'd6:    f = reg_op(f, 8'h0b, 8'h03, rs2);
              default: f = reg_op(f, 8'h23, 8'h03, rs2);
            endcase
            f = store_rd(f, rd);
          end
        end
        f = pc_inc(f);
        f = cyc_inc(f);
      end
      OpAluImm: begin
        if (rd != 5'd0) begin
          if (rs1 == rd && plain) begin
            f = p8(f, 8'h81);
            case (f3)
              3'd0:    f = p8(f, 8'h43);
              3'd4:    f = p8(f, 8'h73);
              3'd6:    f = p8(f, 8'h63);
              default: f = p8(f, 8'h4b);
            endcase
            f = p8(f, {1'b0, rs1, 2'b00});
            f = p32(f, iimm);
          end else begin
            f = reg_op(f, 8'h8b, 8'h03, rs1);
            case (f3)
              3'd1: begin
                f = p8(f, 8'hb1);
                f = p8(f, iimm[7:0]);
                f = p8(f, 8'hd3);
                f = p8(f, 8'he0);
              end
              3'd2, 3'd3: begin
                f = p8(f, 8'h3d);
                f = p32(f, iimm);
                f = p3(f, 8'h31, 8'hc0, RetOp);
                f = p3(f, 8'h0f, (f3 == 3'd2) ? 8'h9c : 8'h92, 8'hc0);
              end
              3'd5: begin
                f = p8(f, 8'hb1);
                f = p8(f, iimm[7:0]);
                f = p8(f, 8'hd3);
                f = p8(f, sub ? 8'hf8 : 8'he8);
              end
              3'd0:    begin f = p8(f, 8'h05); f = p32(f, iimm); end
              3'd4:    begin f = p8(f, 8'h35); f = p32(f, iimm); end
              3'd6:    begin f = p8(f, 8'h0d); f = p32(f, iimm); end
              default: begin f = p8(f, 8'h25); f = p32(f, iimm); end
            endcase
            f = store_rd(f, rd);
          end
        end
        f = pc_inc(f);
        f = cyc_inc(f);
      end
      OpStore, OpLoad: begin
        word = {st ? rs2 : rd, 24'd0, st ? 3'd2 : 3'd1};
        f = reg_op(f, 8'h8b, 8'h03, rs1);
        if ((st ? simm : iimm) != 32'd0) begin
          f = p8(f, 8'h05);
          f = p32(f, st ? simm : iimm);
        end
        if (!st) f = p8(f, 8'h48);
        if (!st) f = p3(f, 8'hc1, 8'he0, 8'h20);
        f = p8(f, MovEcxImm);
        case (f3)
          3'd0: word = word | (32'h1 << 24) | (st ? 32'd0 : (32'h1 << 22));
          3'd1: word = word | (32'h2 << 24) | (st ? 32'd0 : (32'h2 << 22));
          3'd2: word = word | (32'h4 << 24);
          3'd4: if (!st) word = word | (32'h1 << 24); else ok = 1'b0;
          3'd5: if (!st) word = word | (32'h2 << 24); else ok = 1'b0;
          default: ok = 1'b0;
        endcase
        if (!ok) f = epilog(f, inv);
        f = p32(f, word);
        if (st) f = p8(f, 8'h48);
        if (st) f = p3(f, 8'hc1, 8'he0, 8'h20);
        f = p3(f, 8'h48, 8'h09, 8'hc8);
        f = cyc_inc(f);
        f = p8(f, RetOp);
      end
      OpSystem: f = epilog(f, 32'd3);
      default:  f = epilog(f, 32'd4);
    endcase
    return f;
  endfunction

endpackage

[rtl/rce_builder.sv]
// ----------------------------------------------------------------------------
// rce_builder
// input register, configuration registers and combinational fragment build
// ----------------------------------------------------------------------------
module rce_builder import rce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] in_word_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  output logic        frag_valid_o,
  input  logic        frag_take_i,
  output frag_t       frag_o
);

  logic        v_q;
  logic [31:0] w_q;
  logic        save_q;
  logic [31:0] inv_q;
  logic        load;

  // stage moves when the result side takes it or is empty
  assign load         = v_q && frag_take_i;
  assign in_ready_o   = !v_q || load;
  assign frag_valid_o = v_q;
  assign frag_o       = build(w_q, save_q, inv_q);

  // control and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      save_q <= 1'b1;
      inv_q  <= 32'd1;
    end else begin
      if (in_ready_o) v_q <= in_valid_i;
      if (cfg_we_i && cfg_idx_i == CfgSavePrologue) save_q <= cfg_data_i[0];
      if (cfg_we_i && cfg_idx_i == CfgInvalidCode) inv_q <= cfg_data_i;
    end
  end

  // instruction register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) w_q <= in_word_i;
  end

endmodule

[rtl/rce_serializer.sv]
// ----------------------------------------------------------------------------
// rce_serializer
// holds one built fragment and sends it out one byte per transaction
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rce_serializer import rce_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       frag_valid_i,
  output logic       frag_take_o,
  input  frag_t      frag_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic            v_q;
  frag_t           f_q;
  logic [CntW-1:0] idx_q;
  logic            fire, done;

  assign fire        = v_q && out_ready_i;
  assign out_last_o  = (idx_q == f_q.n - CntW'(1));
  assign done        = fire && out_last_o;
  assign frag_take_o = frag_valid_i && (!v_q || done);
  assign out_valid_o = v_q;
  assign out_byte_o  = f_q.b[idx_q];

  // byte pointer and fragment holding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= 1'b0;
      idx_q <= '0;
    end else if (frag_take_o) begin
      v_q   <= 1'b1;
      idx_q <= '0;
    end else if (done) begin
      v_q   <= 1'b0;
    end else if (fire) begin
      idx_q <= idx_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (frag_take_o) f_q <= frag_i;
  end

  `RCE_ASSERT_IF(a_idx_in_range, clk_i, rst_ni, v_q, idx_q < f_q.n, "byte index past end")
  `RCE_ASSERT_IF(a_len_min, clk_i, rst_ni, v_q, f_q.n >= CntW'(3), "fragment too short")
  `RCE_ASSERT_IF(a_take_restart, clk_i, rst_ni, frag_take_o, ##1 (idx_q == '0 && v_q),
                 "new fragment not started at byte zero")

endmodule

[rtl/rv32_to_x86_code_emitter_unit.sv]
// ----------------------------------------------------------------------------
// rv32_to_x86_code_emitter_unit
// turns one rv32i instruction into its x86-64 code fragment, byte by byte
// ----------------------------------------------------------------------------
// channel   dir  tdata / fields                      tlast
// s_axis    in   [31:0] instr_word                   -
// m_axis    out  [7:0]  code_byte                    last_byte
// cfg       in   index 0 emit_save_prologue, 1 invalid_code
//
// an instruction is built combinationally from the input register, captured
// in the fragment register; its bytes then leave at one per cycle while
// m_axis is ready, so the output channel sets the rate. the next instruction
// waits in the input register meanwhile. reset clears all valid state and
// loads the configuration defaults. stalls on m_axis hold the current byte.
// ----------------------------------------------------------------------------
module rv32_to_x86_code_emitter_unit import rce_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] instr_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] code_byte
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  logic  frag_valid, frag_take;
  frag_t frag;

  rce_builder u_builder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_word_i    (s_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .frag_valid_o (frag_valid),
    .frag_take_i  (frag_take),
    .frag_o       (frag)
  );

  rce_serializer u_serializer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frag_valid_i (frag_valid),
    .frag_take_o  (frag_take),
    .frag_i       (frag),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule

[verif/rv32_to_x86_code_emitter_unit_tb.sv]
// ----------------------------------------------------------------------------
// rv32_to_x86_code_emitter_unit_tb
// drives rv32i instruction words into the emitter and checks every x86 code
// byte and its last flag against a fragment predictor kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rv32_to_x86_code_emitter_unit_tb;
  import rce_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] instr_word
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] code_byte
  logic        m_axis_tlast;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [31:0] cfg_data_i;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } code_byte_t;

  // predictor state mirrors the two config registers
  logic        save_prologue_q;
  logic [31:0] invalid_code_q;

  code_byte_t  pending_bytes[$];
  logic [7:0]  frag_buf[$];
  int unsigned errors;
  int unsigned bytes_seen;
  int unsigned instrs_sent;
  int unsigned idle_cycles;
  bit          stall_free;
  bit          hold_off;

  rv32_to_x86_code_emitter_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // byte emit helpers
  function automatic void put_b(logic [7:0] v);
    frag_buf.push_back(v);
  endfunction

  function automatic void put_w(logic [31:0] v);
    put_b(v[7:0]); put_b(v[15:8]); put_b(v[23:16]); put_b(v[31:24]);
  endfunction

  function automatic void put_m(logic [7:0] op, logic [7:0] modrm, logic [4:0] r);
    put_b(op);
    if (r == 5'd0) begin
      put_b(modrm);
    end else begin
      put_b(modrm | 8'h40);
      put_b({1'b0, r, 2'b00});
    end
  endfunction

  function automatic void put_ret(logic [31:0] c);
    if (c == 32'd0) begin
      put_b(8'h31); put_b(8'hc0); put_b(RetOp);
    end else begin
      put_b(8'hb8); put_w(c); put_b(RetOp);
    end
  endfunction

  function automatic void put_rd(logic [4:0] rd);
    if (rd != 5'd0) begin
      put_b(8'h89); put_b(8'h43); put_b({1'b0, rd, 2'b00});
    end
  endfunction

  function automatic void put_pc_cyc();
    put_b(8'h83); put_b(8'h83); put_b(8'h80); put_w(32'h0400_0000 >> 24 << 24);
    put_b(8'h48); put_b(8'hff); put_b(8'h83); put_w(32'h88);
  endfunction

  function automatic void put_cyc();
    put_b(8'h48); put_b(8'hff); put_b(8'h83); put_w(32'h88);
  endfunction

  // x86 fragment for one instruction, queued as expected code bytes
  function automatic void predict_fragment(logic [31:0] w);
    logic [6:0]  opc;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic        sub, plain, st, ok;
    logic [31:0] iimm, imm, off, word;
    logic [7:0]  op8;
    opc = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
    sub = (w[31:25] == SubFunct7);
    plain = (f3 == 3'd0 || f3 == 3'd4 || f3 == 3'd6 || f3 == 3'd7);
    iimm = {{20{w[31]}}, w[31:20]};
    st = (opc == OpStore);
    ok = 1'b1;
    frag_buf.delete();
    if (save_prologue_q && (opc == OpLui || opc == OpAuipc || opc == OpJal ||
        opc == OpJalr || opc == OpBranch || opc == OpAlu || opc == OpAluImm)) begin
      put_b(8'h48); put_b(8'h89); put_b(8'hcb);
    end
    case (opc)
      OpLui, OpAuipc: begin
        if (opc == OpLui) begin
          put_b(8'hb8);
        end else begin
          put_b(8'h8b); put_b(8'h83); put_w(PcOfs); put_b(8'h05);
        end
        put_w({w[31:12], 12'd0});
        put_rd(rd);
        put_pc_cyc();
      end
      OpJal, OpJalr: begin
        put_b(8'h8b); put_b(8'h83); put_w(PcOfs);
        put_b(8'h83); put_b(8'hc0); put_b(8'h04);
        put_rd(rd);
        if (opc == OpJal) begin
          off = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0} - 32'd4;
        end else begin
          put_m(8'h8b, 8'h03, rs1);
          off = iimm - 32'd4;
        end
        if (off != 32'd0) begin
          put_b(8'h05); put_w(off);
        end
        put_b(8'h89); put_b(8'h83); put_w(PcOfs);
        put_cyc();
        put_ret(32'd0);
      end
      OpBranch: begin
        put_m(8'h8b, 8'h03, rs1);
        put_m(8'h3b, 8'h03, rs2);
        if (f3 == 3'd2 || f3 == 3'd3) begin
          put_ret(invalid_code_q);
        end else begin
          case (f3)
            3'd0:    op8 = 8'h95;
            3'd1:    op8 = 8'h94;
            3'd4:    op8 = 8'h9d;
            3'd5:    op8 = 8'h9c;
            3'd6:    op8 = 8'h93;
            default: op8 = 8'h92;
          endcase
          put_b(8'h0f); put_b(op8); put_b(8'hc1);
        end
        put_b(8'hb8);
        put_w({{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0} - 32'd4);
        put_b(8'hc0); put_b(8'he1); put_b(8'h05);
        put_b(8'h48); put_b(8'hd3); put_b(8'he0);
        put_b(8'h83); put_b(8'hc0); put_b(8'h04);
        put_b(8'h01); put_b(8'h83); put_b(8'h80); put_b(8'h00); put_b(8'h00);
        put_b(8'h00);
        put_cyc();
        put_ret(32'd0);
      end
      OpAlu: begin
        if (rd != 5'd0) begin
          if (rs1 == rd && !sub && plain) begin
            put_m(8'h8b, 8'h03, rs2);
            case (f3)
              3'd0:    put_b(8'h01);
              3'd4:    put_b(8'h31);
              3'd6:    put_b(8'h09);
              default: put_b(8'h21);
            endcase
            put_b(8'h43); put_b({1'b0, rs1, 2'b00});
          end else begin
            put_m(8'h8b, 8'h03, rs1);
            case (f3)
              3'd0: put_m(sub ? 8'h2b : 8'h03, 8'h03, rs2);
              3'd1: begin
                put_m(8'h8b, 8'h0b, rs2); put_b(8'hd3); put_b(8'he0);
              end
              3'd2, 3'd3: begin
                put_m(8'h3b, 8'h03, rs2);
                put_ret(32'd0);
                put_b(8'h0f); put_b(f3 == 3'd2 ? 8'h9c : 8'h92); put_b(8'hc0);
              end
              3'd5: begin
                put_m(8'h8b, 8'h0b, rs2); put_b(8'hd3); put_b(sub ? 8'hf8 : 8'he8);
              end
              3'd4:    put_m(8'h33, 8'h03, rs2);
              3'd6:    put_m(8'h0b, 8'h03, rs2);
              default: put_m(8'h23, 8'h03, rs2);
            endcase
            put_rd(rd);
          end
        end
        put_pc_cyc();
      end
      OpAluImm: begin
        if (rd != 5'd0) begin
          if (rs1 == rd && plain) begin
            case (f3)
              3'd0:    op8 = 8'h43;
              3'd4:    op8 = 8'h73;
              3'd6:    op8 = 8'h63;
              default: op8 = 8'h4b;
            endcase
            put_b(8'h81); put_b(op8); put_b({1'b0, rs1, 2'b00}); put_w(iimm);
          end else begin
            put_m(8'h8b, 8'h03, rs1);
            case (f3)
              3'd1: begin
                put_b(8'hb1); put_b(iimm[7:0]); put_b(8'hd3); put_b(8'he0);
              end
              3'd2, 3'd3: begin
                put_b(8'h3d); put_w(iimm);
                put_ret(32'd0);
                put_b(8'h0f); put_b(f3 == 3'd2 ? 8'h9c : 8'h92); put_b(8'hc0);
              end
              3'd5: begin
                put_b(8'hb1); put_b(iimm[7:0]); put_b(8'hd3);
                put_b(sub ? 8'hf8 : 8'he8);
              end
              default: begin
                case (f3)
                  3'd0:    put_b(8'h05);
                  3'd4:    put_b(8'h35);
                  3'd6:    put_b(8'h0d);
                  default: put_b(8'h25);
                endcase
                put_w(iimm);
              end
            endcase
            put_rd(rd);
          end
        end
        put_pc_cyc();
      end
      OpStore, OpLoad: begin
        imm = st ? {{20{w[31]}}, w[31:25], w[11:7]} : iimm;
        word = {(st ? rs2 : rd), 27'd0} | (st ? 32'd2 : 32'd1);
        put_m(8'h8b, 8'h03, rs1);
        if (imm != 32'd0) begin
          put_b(8'h05); put_w(imm);
        end
        if (!st) begin
          put_b(8'h48); put_b(8'hc1); put_b(8'he0); put_b(8'h20);
        end
        put_b(MovEcxImm);
        case (f3)
          3'd0: word |= (32'd1 << 24) | (st ? 32'd0 : 32'd1 << 22);
          3'd1: word |= (32'd2 << 24) | (st ? 32'd0 : 32'd2 << 22);
          3'd2: word |= 32'd4 << 24;
          3'd4: if (!st) word |= 32'd1 << 24; else ok = 1'b0;
          3'd5: if (!st) word |= 32'd2 << 24; else ok = 1'b0;
          default: ok = 1'b0;
        endcase
        if (!ok) put_ret(invalid_code_q);
        put_w(word);
        if (st) begin
          put_b(8'h48); put_b(8'hc1); put_b(8'he0); put_b(8'h20);
        end
        put_b(8'h48); put_b(8'h09); put_b(8'hc8);
        put_cyc();
        put_b(RetOp);
      end
      OpSystem: put_ret(32'd3);
      default:  put_ret(32'd4);
    endcase
    foreach (frag_buf[k])
      pending_bytes.push_back('{code: frag_buf[k], last: (k == frag_buf.size() - 1)});
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp);
    $display("error at %0t: %s got %0h expected %0h", $realtime, what, got, exp);
    errors++;
  endtask

  // output side: random stalls, one long hold-off, checks on each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    code_byte_t exp_b;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
          report_mismatch("unexpected code byte", m_axis_tdata, 0);
        end else begin
          exp_b = pending_bytes.pop_front();
          if (m_axis_tdata !== exp_b.code)
            report_mismatch("code_byte", m_axis_tdata, exp_b.code);
          if (m_axis_tlast !== exp_b.last)
            report_mismatch("last_byte", m_axis_tlast, exp_b.last);
        end
      end
      m_axis_tready <= !hold_off && (stall_free || ($urandom_range(99) >= 24));
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni)
      idle_cycles = 0;
    else if (++idle_cycles >= 4000) begin
      $display("watchdog expired with %0d bytes outstanding", pending_bytes.size());
      $display("rv32_to_x86_code_emitter_unit: mismatch");
      $finish;
    end
  end

  // send one instruction, predicting at acceptance; valid stays up for the next
  task automatic send_instr(logic [31:0] w);
    while (!stall_free && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_fragment(w);
    instrs_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgSavePrologue) save_prologue_q = val[0];
    else invalid_code_q = val;
  endtask

  // random instruction, mostly from covered opcodes
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    logic [6:0]  ops[10];
    ops = '{OpLui, OpAuipc, OpJal, OpJalr, OpBranch, OpAlu, OpAluImm, OpStore,
            OpLoad, OpSystem};
    w = $urandom();
    if ($urandom_range(9) != 0) w[6:0] = ops[$urandom_range(9)];
    if ($urandom_range(3) == 0) w[19:15] = w[11:7];
    if ($urandom_range(3) == 0) w[31:25] = SubFunct7;
    if ($urandom_range(7) == 0) w[11:7] = 5'd0;
    return w;
  endfunction

  // directed table: instruction and, where obvious, the first code byte
  typedef struct {
    logic [31:0] w;
    logic        has_first;
    logic [7:0]  first;
  } dir_row_t;

  dir_row_t dir_rows[] = '{
    '{32'h0000_0073, 1'b1, 8'hb8},  // system: code 3
    '{32'h0000_000b, 1'b1, 8'hb8},  // unknown opcode: code 4
    '{32'hffff_ffff, 1'b1, 8'hb8},  // all ones: unknown opcode
    '{32'hfffff0b7, 1'b1, 8'h48},   // lui, max immediate
    '{32'h0000_0037, 1'b1, 8'h48},  // lui to x0
    '{32'h8000_0097, 1'b0, 8'h00},  // auipc
    '{32'h0040_006f, 1'b0, 8'h00},  // jal offset 4: no add
    '{32'h8000_00ef, 1'b0, 8'h00},  // jal most negative offset
    '{32'hfff0_8067, 1'b0, 8'h00},  // jalr negative immediate
    '{32'h0020_8063, 1'b0, 8'h00},  // beq
    '{32'h0020_a063, 1'b0, 8'h00},  // invalid branch funct3 2
    '{32'hfe20_b0e3, 1'b0, 8'h00},  // invalid branch funct3 3
    '{32'h0000_0033, 1'b0, 8'h00},  // alu to x0
    '{32'h4020_80b3, 1'b0, 8'h00},  // sub rd == rs1
    '{32'h0020_90b3, 1'b0, 8'h00},  // sll rs2 nonzero
    '{32'h4000_d0b3, 1'b0, 8'h00},  // sra count from x0
    '{32'h0010_a133, 1'b0, 8'h00},  // slt
    '{32'h8000_f093, 1'b0, 8'h00},  // andi rd == rs1
    '{32'h41f0_d113, 1'b0, 8'h00},  // srai
    '{32'h0000_3103, 1'b0, 8'h00},  // invalid load funct3, zero offset
    '{32'hfff0_4103, 1'b0, 8'h00},  // lbu
    '{32'hfe20_afa3, 1'b0, 8'h00},  // sw negative offset
    '{32'h0020_4023, 1'b0, 8'h00},  // invalid store funct3 4
    '{32'h7ff0_0003, 1'b0, 8'h00}   // lb max offset
  };

  initial begin
    logic [31:0] cfg_vals[4];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CfgSavePrologue;
    cfg_data_i    = '0;
    save_prologue_q = 1'b1;
    invalid_code_q  = 32'd1;
    errors = 0; bytes_seen = 0; instrs_sent = 0; idle_cycles = 0;
    stall_free = 1'b0; hold_off = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with reset configuration
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_first) begin
        drain();
        send_instr(dir_rows[i].w);
        if (pending_bytes[0].code !== dir_rows[i].first)
          report_mismatch("table first byte", pending_bytes[0].code, dir_rows[i].first);
      end else begin
        send_instr(dir_rows[i].w);
      end
    end
    drain();

    // random phases over several configurations, extremes included
    cfg_vals = '{32'd0, 32'hffff_ffff, 32'd1, 32'h8000_0000};
    for (int ph = 0; ph < 4; ph++) begin
      write_cfg(CfgSavePrologue, 32'(ph[0]));
      write_cfg(CfgInvalidCode, cfg_vals[ph]);
      stall_free = (ph == 2);
      if (ph == 1) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < 70; n++) send_instr(rand_instr());
      drain();
    end
    write_cfg(CfgSavePrologue, 32'd1);
    write_cfg(CfgInvalidCode, $urandom());
    for (int n = 0; n < 20; n++) send_instr(rand_instr());
    drain();

    $display("covered %0d instructions and %0d code bytes over 6 configurations",
             instrs_sent, bytes_seen);
    if (errors == 0) begin
      $display("rv32_to_x86_code_emitter_unit: match");
    end else begin
      $display("rv32_to_x86_code_emitter_unit: mismatch");
    end
    $finish;
  end

endmodule
